[rtl/sitda_pkg.sv]
package sitda_pkg;

	localparam int MagWidth     = 32;
	localparam int NumDigits    = 10;
	localparam int BcdWidth     = 4 * NumDigits;
	localparam int BitsPerStage = 4;
	localparam int NumStages    = MagWidth / BitsPerStage;
	localparam int CharWidth    = 8;

	localparam logic [CharWidth-1:0] CharZero  = 8'h30;
	localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
	localparam logic [3:0]           LastDigit = 4'(NumDigits - 1);

	// Conversion state carried down the shift-and-add-3 pipeline.
	typedef struct packed {
		logic                neg;
		logic [MagWidth-1:0] bin;
		logic [BcdWidth-1:0] bcd;
	} work_t;

	// Finished conversion handed to the character serializer.
	typedef struct packed {
		logic                neg;
		logic [BcdWidth-1:0] bcd;
	} digits_t;

	// Index of the most significant nonzero digit, zero when all digits are zero.
	function automatic logic [3:0] lead_digit(input logic [BcdWidth-1:0] bcd);
		logic [3:0] pos;
		pos = '0;
		for (int d = 0; d < NumDigits; d++) begin
			if (bcd[4*d +: 4] != 4'd0) begin
				pos = 4'(d);
			end
		end
		return pos;
	endfunction

endpackage

[rtl/sitda_dabble_stage.sv]
module sitda_dabble_stage
	import sitda_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  work_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output work_t out_data
);

	logic  valid_s1;
	work_t data_s1;
	work_t next_data;

	assign in_ready = !valid_s1 || out_ready;

	// Consume the next few magnitude bits, most significant first.
	always_comb begin
		next_data = in_data;
		for (int i = 0; i < BitsPerStage; i++) begin
			for (int d = 0; d < NumDigits; d++) begin
				if (next_data.bcd[4*d +: 4] >= 4'd5) begin
					next_data.bcd[4*d +: 4] = next_data.bcd[4*d +: 4] + 4'd3;
				end
			end
			next_data.bcd = {next_data.bcd[BcdWidth-2:0], next_data.bin[MagWidth-1]};
			next_data.bin = {next_data.bin[MagWidth-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next_data;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[rtl/sitda_serializer.sv]
module sitda_serializer
	import sitda_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  digits_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CharWidth-1:0] out_char,
	output logic                 out_last
);

	logic                busy_q;
	logic                neg_q;
	logic [3:0]          pos_q;
	logic [BcdWidth-1:0] bcd_q;
	logic [3:0]          digit;
	logic                load;
	logic                take;

	assign digit     = bcd_q[4*pos_q +: 4];
	assign out_valid = busy_q;
	assign out_char  = neg_q ? CharMinus : (CharZero + {4'd0, digit});
	assign out_last  = !neg_q && (pos_q == 4'd0);

	assign take     = busy_q && out_ready;
	assign in_ready = !busy_q || (take && out_last);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			neg_q  <= in_data.neg;
			pos_q  <= lead_digit(in_data.bcd);
		end else if (take) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else if (pos_q == 4'd0) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= in_data.bcd;
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= LastDigit))
		else $error("digit position beyond the last digit");
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((out_char == CharMinus) ||
			((out_char >= CharZero) && (out_char <= CharZero + 8'd9))))
		else $error("character is neither a minus sign nor a digit");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && out_last && !in_valid) |=> !busy_q)
		else $error("serializer still busy after the final character");
	a_no_stray_minus: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !neg_q)
		else $error("minus sign pending while idle");
`endif

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// A request passes the front register and the dabble stages before the serializer.
// Throughput: a request occupies the character serializer for 1 to 11 characters
// (sign plus significant digits), each held until taken; the conversion pipeline accepts a
// new request every cycle while the serializer keeps up.
// Reset: arst_n is asynchronous and active low; it empties every stage and the serializer.
module signed_int_to_decimal_ascii_unit
	import sitda_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,  // [31:0] value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CharWidth-1:0] m_tdata,  // [7:0] character
	output logic                 m_tlast   // last
);

	// The front register takes the sign and the 32-bit magnitude. Negating in
	// unsigned arithmetic makes the most negative value come out as 2^31 exactly.
	logic  front_valid_s1;
	work_t front_data_s1;

	// Chain of shift-and-add-3 stages. Entry 0 is fed by the front register and
	// entry NumStages holds the finished BCD digits.
	logic  stage_valid [NumStages+1];
	logic  stage_ready [NumStages+1];
	work_t stage_data  [NumStages+1];

	digits_t conv_digits;

	// Each stage accepts whenever its register is empty or its contents move on,
	// so a stall anywhere downstream backs up without dropping or duplicating work.
	assign s_tready = !front_valid_s1 || stage_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			front_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			front_data_s1.neg <= s_tdata[31];
			front_data_s1.bin <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
			front_data_s1.bcd <= '0;
		end
	end

	assign stage_valid[0] = front_valid_s1;
	assign stage_data[0]  = front_data_s1;

	// Each stage folds four magnitude bits into the ten BCD digits, so eight
	// stages cover the whole 32-bit magnitude.
	for (genvar g = 0; g < NumStages; g++) begin : g_dabble
		sitda_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[g]),
			.in_ready  (stage_ready[g]),
			.in_data   (stage_data[g]),
			.out_valid (stage_valid[g+1]),
			.out_ready (stage_ready[g+1]),
			.out_data  (stage_data[g+1])
		);
	end

	assign conv_digits.neg = stage_data[NumStages].neg;
	assign conv_digits.bcd = stage_data[NumStages].bcd;

	// The serializer skips leading zeros, sends the minus sign first when needed,
	// then one digit per cycle while m_tready is high, and flags the final one with
	// tlast. It loads the next request in the same cycle as the final character leaves.
	sitda_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stage_valid[NumStages]),
		.in_ready  (stage_ready[NumStages]),
		.in_data   (conv_digits),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
